[sv/otsu_pkg.sv]
`timescale 1ns / 1ps
package otsu_pkg;

  localparam int CNT_W  = 24;
  localparam int VAL_W  = 16;
  localparam int CT_W   = 25;
  localparam int WT_W   = 40;
  localparam int D_W    = 64;
  localparam int Q_W    = 48;
  localparam int DSQ_W  = 128;
  localparam int CMP_W  = 176;
  localparam int MX_W   = 128;
  localparam int MY_W   = 64;
  localparam int MP_W   = MX_W + MY_W;
  localparam logic [CNT_W-1:0] PIXELS_RST = 24'd65536;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_CAP  = 2'd3;

  typedef enum logic [2:0] {
    MS_A,
    MS_B,
    MS_SQ,
    MS_L,
    MS_R
  } mul_sel_t;

  typedef struct packed {
    logic       load;
    logic       init;
    logic       rd;
    logic       acc;
    logic       mul_go;
    mul_sel_t   mul_sel;
    logic       diff;
    logic       take;
    logic       emit;
    logic       zero_thr;
    logic [1:0] code;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic over;
    logic cap;
    logic all_read;
    logic first;
    logic neg;
    logic greater;
    logic mul_done;
  } sts_t;

endpackage

[sv/otsu_threshold_search.sv]
// Bins load one per cycle while in_stall is low; the cycle that takes the last bin starts the search.
// Search: a bin whose running count is 0 or at least N is only read and summed; any other
// bin also goes through the shared one-bit-per-cycle multiplier.
// A check comes before the search and the result is registered; the next set waits until it is emitted.
// rst_n is synchronous: it clears the sums, bin count and flags and sets N to 65536.
`timescale 1ns / 1ps
module otsu_threshold_search #(
  parameter int MAX_BINS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [otsu_pkg::CNT_W-1:0] in_bin_count,
  input  logic [otsu_pkg::VAL_W-1:0] in_bin_value,
  input  logic                       in_last_bin,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [otsu_pkg::VAL_W-1:0] out_threshold,
  output logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [otsu_pkg::CNT_W-1:0] cfg_image_pixels
);
  import otsu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  otsu_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_bin (in_last_bin),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  otsu_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_bin_count     (in_bin_count),
    .in_bin_value     (in_bin_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_image_pixels (cfg_image_pixels),
    .out_threshold    (out_threshold),
    .out_status       (out_status)
  );

endmodule

[sv/otsu_mul.sv]
`timescale 1ns / 1ps
module otsu_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [otsu_pkg::MX_W-1:0] x,
  input  logic [otsu_pkg::MY_W-1:0] y,
  output logic                     done,
  output logic [otsu_pkg::MP_W-1:0] p
);
  import otsu_pkg::*;

  localparam int SW = $clog2(MY_W);

  logic [MP_W-1:0] xs_r;
  logic [MY_W-1:0] ys_r;
  logic [MP_W-1:0] acc_r;
  logic [SW-1:0]   step_r;
  logic            busy_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        xs_r   <= {{MY_W{1'b0}}, x};
        ys_r   <= y;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ys_r[0]) begin
          acc_r <= acc_r + xs_r;
        end
        xs_r   <= xs_r << 1;
        ys_r   <= ys_r >> 1;
        step_r <= step_r + 1'b1;
        if (step_r == SW'(MY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

[sv/otsu_dp.sv]
`timescale 1ns / 1ps
module otsu_dp #(
  parameter int MAX_BINS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  otsu_pkg::cmd_t             cmd,
  output otsu_pkg::sts_t             sts,
  input  logic [otsu_pkg::CNT_W-1:0] in_bin_count,
  input  logic [otsu_pkg::VAL_W-1:0] in_bin_value,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [otsu_pkg::CNT_W-1:0] cfg_image_pixels,
  output logic [otsu_pkg::VAL_W-1:0] out_threshold,
  output logic [1:0]                 out_status
);
  import otsu_pkg::*;

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int BW = $clog2(MAX_BINS + 1);

  logic [CNT_W-1:0] cnt_mem [MAX_BINS];
  logic [VAL_W-1:0] val_mem [MAX_BINS];

  logic [CNT_W-1:0] n_r;
  logic [BW-1:0]    bins_r;
  logic [CT_W-1:0]  ct_r;
  logic [WT_W-1:0]  wt_r;
  logic             cap_r;
  logic [BW-1:0]    idx_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic [VAL_W-1:0] rd_val_r;
  logic [CT_W-1:0]  w_r;
  logic [WT_W-1:0]  s_r;
  logic [D_W-1:0]   a_r;
  logic [D_W-1:0]   b_r;
  logic [D_W-1:0]   d_r;
  logic [Q_W-1:0]   q_r;
  logic [DSQ_W-1:0] dsq_r;
  logic [DSQ_W-1:0] best_dsq_r;
  logic [Q_W-1:0]   best_q_r;
  logic [CMP_W-1:0] left_r;
  logic [CMP_W-1:0] right_r;
  logic [VAL_W-1:0] thr_r;
  logic [VAL_W-1:0] out_threshold_r;
  logic [1:0]       out_status_r;
  mul_sel_t         sel_r;

  logic [CT_W:0]    ct_sum;
  logic [WT_W-1:0]  prod_in;
  logic [WT_W:0]    wt_sum;
  logic [CNT_W-1:0] nw;
  logic [MX_W-1:0]  mx;
  logic [MY_W-1:0]  my;
  logic             mdone;
  logic [MP_W-1:0]  mp;

  assign ct_sum  = {1'b0, ct_r} + (CT_W + 1)'(in_bin_count);
  assign prod_in = WT_W'(in_bin_count) * WT_W'(in_bin_value);
  assign wt_sum  = {1'b0, wt_r} + {1'b0, prod_in};
  assign nw      = n_r - w_r[CNT_W-1:0];

  always_comb begin
    unique case (cmd.mul_sel)
      MS_A: begin
        mx = MX_W'(wt_r);
        my = MY_W'(w_r);
      end
      MS_B: begin
        mx = MX_W'(s_r);
        my = MY_W'(n_r);
      end
      MS_SQ: begin
        mx = MX_W'(d_r);
        my = d_r;
      end
      MS_L: begin
        mx = dsq_r;
        my = MY_W'(best_q_r);
      end
      MS_R: begin
        mx = best_dsq_r;
        my = MY_W'(q_r);
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  otsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_go),
    .x     (mx),
    .y     (my),
    .done  (mdone),
    .p     (mp)
  );

  always_ff @(posedge clk) begin
    if (cmd.load && (bins_r < BW'(MAX_BINS))) begin
      cnt_mem[bins_r[AW-1:0]] <= in_bin_count;
      val_mem[bins_r[AW-1:0]] <= in_bin_value;
    end
    if (cmd.rd) begin
      rd_cnt_r <= cnt_mem[idx_r[AW-1:0]];
      rd_val_r <= val_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= PIXELS_RST;
      bins_r <= '0;
      ct_r   <= '0;
      wt_r   <= '0;
      cap_r  <= 1'b0;
      idx_r  <= '0;
      sel_r  <= MS_A;
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_r <= cfg_image_pixels;
      end
      if (cmd.clear) begin
        bins_r <= '0;
        ct_r   <= '0;
        wt_r   <= '0;
        cap_r  <= 1'b0;
      end else if (cmd.load) begin
        if (bins_r < BW'(MAX_BINS)) begin
          bins_r <= bins_r + 1'b1;
          ct_r   <= ct_sum[CT_W] ? {CT_W{1'b1}} : ct_sum[CT_W-1:0];
          wt_r   <= wt_sum[WT_W] ? {WT_W{1'b1}} : wt_sum[WT_W-1:0];
        end else begin
          cap_r <= 1'b1;
        end
      end
      if (cmd.init) begin
        idx_r <= '0;
      end else if (cmd.rd) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.mul_go) begin
        sel_r <= cmd.mul_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      w_r <= '0;
      s_r <= '0;
    end else if (cmd.acc) begin
      w_r <= w_r + CT_W'(rd_cnt_r);
      s_r <= s_r + WT_W'(rd_cnt_r) * WT_W'(rd_val_r);
    end
    if (mdone) begin
      unique case (sel_r)
        MS_A:    a_r     <= mp[D_W-1:0];
        MS_B:    b_r     <= mp[D_W-1:0];
        MS_SQ:   dsq_r   <= mp[DSQ_W-1:0];
        MS_L:    left_r  <= mp[CMP_W-1:0];
        MS_R:    right_r <= mp[CMP_W-1:0];
        default: a_r     <= a_r;
      endcase
    end
    if (cmd.diff) begin
      d_r <= (a_r >= b_r) ? (a_r - b_r) : (b_r - a_r);
      q_r <= Q_W'(w_r[CNT_W-1:0]) * Q_W'(nw);
    end
    if (cmd.take) begin
      best_dsq_r <= dsq_r;
      best_q_r   <= q_r;
      thr_r      <= rd_val_r;
    end
    if (cmd.emit) begin
      out_threshold_r <= cmd.zero_thr ? '0 : thr_r;
      out_status_r    <= cmd.code;
    end
  end

  assign sts.few      = bins_r < BW'(2);
  assign sts.over     = ct_r > {1'b0, n_r};
  assign sts.cap      = cap_r;
  assign sts.all_read = idx_r == bins_r;
  assign sts.first    = idx_r == BW'(1);
  assign sts.neg      = (w_r == '0) || (w_r >= {1'b0, n_r});
  assign sts.greater  = left_r > right_r;
  assign sts.mul_done = mdone;

  assign out_threshold = out_threshold_r;
  assign out_status    = out_status_r;

endmodule

[sv/otsu_ctrl.sv]
`timescale 1ns / 1ps
module otsu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_bin,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output otsu_pkg::cmd_t cmd,
  input  otsu_pkg::sts_t sts
);
  import otsu_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD,
    S_CHECK,
    S_RD,
    S_ACC,
    S_NEG,
    S_MA,
    S_MA_W,
    S_MB,
    S_MB_W,
    S_DIFF,
    S_MSQ,
    S_MSQ_W,
    S_SEL,
    S_ML,
    S_ML_W,
    S_MR,
    S_MR_W,
    S_CMP,
    S_DONE
  } state_t;

  state_t     state_r;
  logic       best_neg_r;
  logic [1:0] code_r;
  logic       zero_r;
  logic       out_valid_r;
  logic       emit_ok;

  assign emit_ok = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MS_A;
    cmd.code     = code_r;
    cmd.zero_thr = zero_r;
    unique case (state_r)
      S_LOAD:  cmd.load = in_valid;
      S_CHECK: cmd.init = !sts.few && !sts.over;
      S_RD:    cmd.rd = 1'b1;
      S_ACC:   cmd.acc = 1'b1;
      S_NEG:   cmd.take = sts.neg && sts.first;
      S_MA: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_A;
      end
      S_MB: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_B;
      end
      S_DIFF:  cmd.diff = 1'b1;
      S_MSQ: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_SQ;
      end
      S_SEL:   cmd.take = sts.first || best_neg_r;
      S_ML: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_L;
      end
      S_MR: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_R;
      end
      S_CMP:   cmd.take = sts.greater;
      S_DONE: begin
        cmd.emit  = emit_ok;
        cmd.clear = emit_ok;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      best_neg_r  <= 1'b1;
      code_r      <= ST_OK;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE) || (out_valid_r && out_stall);
      unique case (state_r)
        S_LOAD: begin
          if (in_valid && in_last_bin) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          best_neg_r <= 1'b1;
          priority if (sts.few) begin
            code_r  <= ST_FEW;
            zero_r  <= 1'b1;
            state_r <= S_DONE;
          end else if (sts.over) begin
            code_r  <= ST_OVER;
            zero_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            code_r  <= sts.cap ? ST_CAP : ST_OK;
            zero_r  <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_RD:    state_r <= S_ACC;
        S_ACC:   state_r <= S_NEG;
        S_NEG: begin
          if (!sts.neg) begin
            state_r <= S_MA;
          end else begin
            state_r <= sts.all_read ? S_DONE : S_RD;
          end
        end
        S_MA:    state_r <= S_MA_W;
        S_MA_W:  if (sts.mul_done) state_r <= S_MB;
        S_MB:    state_r <= S_MB_W;
        S_MB_W:  if (sts.mul_done) state_r <= S_DIFF;
        S_DIFF:  state_r <= S_MSQ;
        S_MSQ:   state_r <= S_MSQ_W;
        S_MSQ_W: if (sts.mul_done) state_r <= S_SEL;
        S_SEL: begin
          if (sts.first || best_neg_r) begin
            best_neg_r <= 1'b0;
            state_r    <= sts.all_read ? S_DONE : S_RD;
          end else begin
            state_r <= S_ML;
          end
        end
        S_ML:    state_r <= S_ML_W;
        S_ML_W:  if (sts.mul_done) state_r <= S_MR;
        S_MR:    state_r <= S_MR_W;
        S_MR_W:  if (sts.mul_done) state_r <= S_CMP;
        S_CMP:   state_r <= sts.all_read ? S_DONE : S_RD;
        S_DONE: begin
          if (emit_ok) begin
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_stall  = state_r != S_LOAD;
  assign out_valid = out_valid_r;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import otsu_pkg::*;

  typedef struct {
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] val;
    logic             last;
  } bin_t;

  typedef struct {
    logic [VAL_W-1:0] thr;
    logic [1:0]       status;
  } thr_result_t;

  localparam int NBINS = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CNT_W-1:0] in_bin_count = '0;
  logic [VAL_W-1:0] in_bin_value = '0;
  logic in_last_bin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VAL_W-1:0] out_threshold;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_image_pixels = '0;

  bin_t pending_bins[$];
  thr_result_t expected_thr[$];
  logic in_took = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;

  logic [CNT_W-1:0] pixels_n = PIXELS_RST;
  logic [CNT_W-1:0] hist_cnt[NBINS];
  logic [VAL_W-1:0] hist_val[NBINS];
  int bins_held = 0;
  logic [63:0] sum_weighted = '0;
  logic [63:0] sum_count = '0;
  logic dropped = 1'b0;

  otsu_threshold_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_bin_count(in_bin_count), .in_bin_value(in_bin_value), .in_last_bin(in_last_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_threshold(out_threshold), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_image_pixels(cfg_image_pixels)
  );

  always #2 clk = ~clk;

  function automatic bit variance_greater(logic [63:0] dc, logic [63:0] qc,
                                          logic [63:0] db, logic [63:0] qb);
    logic [175:0] lhs;
    logic [175:0] rhs;
    lhs = {112'd0, dc} * {112'd0, dc};
    lhs = lhs * {112'd0, qb};
    rhs = {112'd0, db} * {112'd0, db};
    rhs = rhs * {112'd0, qc};
    return lhs > rhs;
  endfunction

  function automatic logic [VAL_W-1:0] otsu_search();
    logic [63:0] n;
    logic [63:0] w;
    logic [63:0] s;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] best_d;
    logic [63:0] best_q;
    logic [VAL_W-1:0] thr;
    bit neg;
    bit best_neg;
    n = {40'd0, pixels_n};
    w = '0;
    s = '0;
    best_d = '0;
    best_q = 64'd1;
    best_neg = 1'b1;
    thr = hist_val[0];
    for (int i = 0; i < bins_held; i++) begin
      w = w + {40'd0, hist_cnt[i]};
      s = s + {40'd0, hist_cnt[i]} * {48'd0, hist_val[i]};
      neg = (w == 64'd0) || (w >= n);
      d = '0;
      q = 64'd1;
      if (!neg) begin
        a = sum_weighted * w;
        b = s * n;
        d = (a >= b) ? a - b : b - a;
        q = w * (n - w);
      end
      if (i == 0) begin
        best_neg = neg;
        best_d = d;
        best_q = q;
      end else if (!neg && (best_neg || variance_greater(d, q, best_d, best_q))) begin
        best_neg = 1'b0;
        best_d = d;
        best_q = q;
        thr = hist_val[i];
      end
    end
    return thr;
  endfunction

  task automatic load_bin(bin_t b);
    thr_result_t r;
    if (bins_held < NBINS) begin
      hist_cnt[bins_held] = b.cnt;
      hist_val[bins_held] = b.val;
      bins_held++;
      sum_count = sum_count + {40'd0, b.cnt};
      if (sum_count > 64'h1FF_FFFF) sum_count = 64'h1FF_FFFF;
      sum_weighted = sum_weighted + {40'd0, b.cnt} * {48'd0, b.val};
      if (sum_weighted > 64'hFF_FFFF_FFFF) sum_weighted = 64'hFF_FFFF_FFFF;
    end else begin
      dropped = 1'b1;
    end
    if (b.last) begin
      r.thr = '0;
      if (bins_held < 2) begin
        r.status = ST_FEW;
      end else if (sum_count > {40'd0, pixels_n}) begin
        r.status = ST_OVER;
      end else begin
        r.thr = otsu_search();
        r.status = dropped ? ST_CAP : ST_OK;
      end
      expected_thr.push_back(r);
      bins_held = 0;
      sum_weighted = '0;
      sum_count = '0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    thr_result_t e;
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      load_bin('{in_bin_count, in_bin_value, in_last_bin});
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_thr.size() == 0) begin
        $error("unexpected result threshold %0d status %0d", out_threshold, out_status);
        errors++;
      end else begin
        e = expected_thr.pop_front();
        if (out_threshold !== e.thr) begin
          $error("threshold expected %0d actual %0d", e.thr, out_threshold);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    bin_t b;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_bins.size() > 0 && $urandom_range(99) >= idle_pct) begin
        b = pending_bins.pop_front();
        in_bin_count <= b.cnt;
        in_bin_value <= b.val;
        in_last_bin <= b.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic push_bin(logic [CNT_W-1:0] c, logic [VAL_W-1:0] v, logic l);
    pending_bins.push_back('{c, v, l});
  endtask

  task automatic push_set(int len, bit fit);
    logic [31:0] left;
    logic [31:0] c;
    left = {8'd0, pixels_n};
    for (int i = 0; i < len; i++) begin
      if (!fit) begin
        c = $urandom_range(24'hFF_FFFF);
      end else if ($urandom_range(9) == 0) begin
        c = 0;
      end else begin
        c = $urandom_range((i % 2) ? left : left / (len - i));
        left = left - c;
      end
      push_bin(c[CNT_W-1:0], VAL_W'($urandom_range(16'hFFFF)), i == len - 1);
    end
  endtask

  task automatic drain();
    wait (pending_bins.size() == 0);
    do @(posedge clk); while (in_valid || expected_thr.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pixels(logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_image_pixels <= v;
    do @(posedge clk); while (!cfg_ready);
    pixels_n = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int nitems);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < nitems) begin
      pick = $urandom_range(99);
      len = $urandom_range(2, 12);
      if (pick < 82) begin
        push_set(len, 1'b1);
      end else if (pick < 92) begin
        push_set(len, 1'b0);
      end else begin
        len = 1;
        push_set(1, 1'b1);
      end
      sent += len;
      if (pending_bins.size() > 30) wait (pending_bins.size() < 10);
    end
    drain();
  endtask

  initial begin
    int idle_mode[4];
    int stall_mode[4];
    logic [CNT_W-1:0] n_list[6];
    idle_mode = '{0, 65, 0, 21};
    stall_mode = '{0, 0, 65, 21};
    n_list = '{24'd1, 24'hFF_FFFF, 24'd300, 24'd0, 24'd65536, 24'd4096};
    n_list[3] = CNT_W'($urandom_range(2, 24'hFF_FFFF));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_bin(24'd500, 16'd7, 1'b1);
    push_bin(24'd0, 16'd1234, 1'b0);
    push_bin(24'd0, 16'hFFFF, 1'b1);
    push_bin(24'd100, 16'd10, 1'b0);
    push_bin(24'd200, 16'd20, 1'b0);
    push_bin(24'd100, 16'd30, 1'b1);
    push_bin(24'd65536, 16'd5, 1'b0);
    push_bin(24'd1, 16'd6, 1'b1);
    push_bin(24'd30000, 16'd0, 1'b0);
    push_bin(24'd35536, 16'hFFFF, 1'b1);
    drain();
    write_pixels(24'hFF_FFFF);
    push_bin(24'hFF_FFFF, 16'hFFFF, 1'b0);
    push_bin(24'd0, 16'd0, 1'b1);
    push_bin(24'd0, 16'h5555, 1'b0);
    push_bin(24'hAA_AAAA, 16'hAAAA, 1'b0);
    push_bin(24'h55_5555, 16'h5555, 1'b1);
    push_bin(24'hFF_FFFF, 16'd1, 1'b0);
    push_bin(24'd1, 16'd2, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_pixels(n_list[p]);
      idle_pct = idle_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      if (p == 2) begin
        for (int i = 0; i < 258; i++)
          push_bin(CNT_W'($urandom_range(1)), VAL_W'($urandom_range(16'hFFFF)), i == 257);
        drain();
      end
      random_phase(120);
    end
    idle_pct = 0;
    stall_pct = 0;
    write_pixels(24'd65536);
    for (int i = 0; i < 256; i++)
      push_bin(CNT_W'($urandom_range(255)), VAL_W'($urandom_range(16'hFFFF)), i == 255);
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
sv/otsu_pkg.sv
sv/otsu_mul.sv
sv/otsu_dp.sv
sv/otsu_ctrl.sv
sv/otsu_threshold_search.sv
dv/tb_top.sv
